[hdl/utf8_validating_pretokenizer_top_assert.svh]
// assertion macros used by the pretokenizer result register module
`ifndef UTF8_VALIDATING_PRETOKENIZER_TOP_ASSERT_SVH
`define UTF8_VALIDATING_PRETOKENIZER_TOP_ASSERT_SVH

// clocked assertion, disabled while reset is active
`define UVP_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked on the following clock edge
`define UVP_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

[hdl/utf8vp_pkg.sv]
// types, constants and byte classifiers for the utf-8 validating pretokenizer
package utf8vp_pkg;

	localparam int BUNDLE_DEPTH = 5;
	localparam int IDX_W        = $clog2(BUNDLE_DEPTH);
	localparam int HELD_DEPTH   = 3;

	// result kinds
	localparam logic [1:0] KIND_WORD    = 2'd0;
	localparam logic [1:0] KIND_END_OK  = 2'd1;
	localparam logic [1:0] KIND_END_BAD = 2'd2;

	// lead byte ranges and scalar limits
	localparam logic [7:0]  LEAD2_LO   = 8'hc2;
	localparam logic [7:0]  LEAD2_HI   = 8'hdf;
	localparam logic [7:0]  LEAD3_LO   = 8'he0;
	localparam logic [7:0]  LEAD3_HI   = 8'hef;
	localparam logic [7:0]  LEAD4_LO   = 8'hf0;
	localparam logic [7:0]  LEAD4_HI   = 8'hf4;
	localparam logic [20:0] MIN_3BYTE  = 21'h000800;
	localparam logic [20:0] MIN_4BYTE  = 21'h010000;
	localparam logic [20:0] SURR_LO    = 21'h00d800;
	localparam logic [20:0] SURR_HI    = 21'h00dfff;
	localparam logic [20:0] SCALAR_MAX = 21'h10ffff;
	localparam logic [7:0]  UPPER_A    = 8'h41;
	localparam logic [7:0]  UPPER_Z    = 8'h5a;
	localparam logic [7:0]  CASE_DELTA = 8'h20;

	// sequencing state kept between bytes
	typedef struct packed {
		logic        in_word;
		logic [2:0]  exp_len;
		logic [1:0]  held_count;
		logic [20:0] code;
		logic        err;
	} seq_state_t;

	typedef logic [HELD_DEPTH-1:0][7:0] held_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [IDX_W-1:0]                   count;
		logic [BUNDLE_DEPTH-1:0][7:0]       bytes;
		logic [BUNDLE_DEPTH-1:0]            start;
		logic [BUNDLE_DEPTH-1:0][1:0]       kind;
	} bundle_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return (b >= 8'h21 && b <= 8'h2f) || (b >= 8'h3a && b <= 8'h40) ||
		       (b >= 8'h5b && b <= 8'h60) || (b >= 8'h7b && b <= 8'h7e);
	endfunction

endpackage

[hdl/utf8vp_decode.sv]
// single-pass byte decode: next sequencing state and the result bundle
module utf8vp_decode (
	input  logic                    lowercase,
	input  logic [7:0]              data,
	input  logic                    eot,
	input  utf8vp_pkg::seq_state_t  st,
	input  utf8vp_pkg::held_t       held,
	output utf8vp_pkg::seq_state_t  nxt,
	output utf8vp_pkg::held_t       nxt_held,
	output utf8vp_pkg::bundle_t     bun
);
	import utf8vp_pkg::*;

	logic [IDX_W-1:0] n;
	logic [20:0]      cont_code;
	logic             range_bad;
	logic [7:0]       folded;

	assign cont_code = {st.code[14:0], data[5:0]};
	assign range_bad = (st.exp_len == 3'd3 && cont_code < MIN_3BYTE) ||
	                   (st.exp_len == 3'd4 && cont_code < MIN_4BYTE) ||
	                   (cont_code >= SURR_LO && cont_code <= SURR_HI) ||
	                   (cont_code > SCALAR_MAX);
	assign folded = (lowercase && data >= UPPER_A && data <= UPPER_Z) ?
	                data + CASE_DELTA : data;

	// byte classification and result building
	always_comb begin
		nxt      = st;
		nxt_held = held;
		bun      = '0;
		n        = '0;
		if (!st.err) begin
			if (st.exp_len != 3'd0) begin
				if (data[7:6] != 2'b10) begin
					nxt = '{in_word: 1'b0, exp_len: 3'd0, held_count: 2'd0, code: '0, err: 1'b1};
				end else if ({1'b0, st.held_count} + 3'd1 >= st.exp_len) begin
					if (range_bad) begin
						nxt = '{in_word: 1'b0, exp_len: 3'd0, held_count: 2'd0, code: '0,
						        err: 1'b1};
					end else begin
						// release the held bytes and this one as a word
						for (int i = 0; i < HELD_DEPTH; i++) begin
							if (i < int'(st.held_count)) begin
								bun.bytes[n] = held[i];
								bun.start[n] = (i == 0);
								bun.kind[n]  = KIND_WORD;
								n            = n + 1'b1;
							end
						end
						bun.bytes[n] = data;
						bun.start[n] = 1'b0;
						bun.kind[n]  = KIND_WORD;
						n            = n + 1'b1;
						nxt = '{in_word: 1'b0, exp_len: 3'd0, held_count: 2'd0, code: '0,
						        err: 1'b0};
					end
				end else begin
					// continuation byte held until the scalar completes
					nxt.code                = cont_code;
					nxt_held[st.held_count] = data;
					nxt.held_count          = st.held_count + 2'd1;
				end
			end else if (!data[7]) begin
				if (is_space(data)) begin
					nxt.in_word = 1'b0;
				end else if (is_punct(data)) begin
					bun.bytes[n] = data;
					bun.start[n] = 1'b1;
					bun.kind[n]  = KIND_WORD;
					n            = n + 1'b1;
					nxt.in_word  = 1'b0;
				end else begin
					bun.bytes[n] = folded;
					bun.start[n] = !st.in_word;
					bun.kind[n]  = KIND_WORD;
					n            = n + 1'b1;
					nxt.in_word  = 1'b1;
				end
			end else if (data >= LEAD2_LO && data <= LEAD2_HI) begin
				nxt = '{in_word: 1'b0, exp_len: 3'd2, held_count: 2'd1,
				        code: {16'd0, data[4:0]}, err: 1'b0};
				nxt_held[0] = data;
			end else if (data >= LEAD3_LO && data <= LEAD3_HI) begin
				nxt = '{in_word: 1'b0, exp_len: 3'd3, held_count: 2'd1,
				        code: {17'd0, data[3:0]}, err: 1'b0};
				nxt_held[0] = data;
			end else if (data >= LEAD4_LO && data <= LEAD4_HI) begin
				nxt = '{in_word: 1'b0, exp_len: 3'd4, held_count: 2'd1,
				        code: {18'd0, data[2:0]}, err: 1'b0};
				nxt_held[0] = data;
			end else begin
				nxt = '{in_word: 1'b0, exp_len: 3'd0, held_count: 2'd0, code: '0, err: 1'b1};
			end
		end
		// end marker, then a fresh text
		if (eot) begin
			bun.bytes[n] = 8'd0;
			bun.start[n] = 1'b0;
			bun.kind[n]  = (nxt.err || nxt.exp_len != 3'd0) ? KIND_END_BAD : KIND_END_OK;
			n            = n + 1'b1;
			nxt = '{in_word: 1'b0, exp_len: 3'd0, held_count: 2'd0, code: '0, err: 1'b0};
		end
		bun.count = n;
	end

endmodule

[hdl/utf8vp_emit.sv]
// result register that hands out one bundle entry per transaction
`include "utf8_validating_pretokenizer_top_assert.svh"

module utf8vp_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  utf8vp_pkg::bundle_t  bun,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 word_start,
	output logic [1:0]           kind,
	output logic                 last_of_run
);
	import utf8vp_pkg::*;

	bundle_t          bun_s2;
	logic             valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             is_last;
	logic             done;

	assign is_last = (idx_q == bun_s2.count - 1'b1);
	assign done    = valid_q && out_ready && is_last;
	assign free    = !valid_q || done;

	// bundle payload
	always_ff @(posedge clk) begin
		if (load) begin
			bun_s2 <= bun;
		end
	end

	// entry pointer and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= (bun.count != '0);
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// current entry onto the ports
	assign out_valid   = valid_q;
	assign out_byte    = bun_s2.bytes[idx_q];
	assign word_start  = bun_s2.start[idx_q];
	assign kind        = bun_s2.kind[idx_q];
	assign last_of_run = is_last;

	`UVP_ASSERT_CLK(a_idx_in_range, valid_q |-> (idx_q < bun_s2.count), "entry pointer past bundle")
	`UVP_ASSERT_CLK(a_load_when_free, load |-> free, "bundle overwritten before drained")
	`UVP_ASSERT_NEXT(a_drain_clears, done && !load, !valid_q, "valid held after last entry")

endmodule

[hdl/utf8_validating_pretokenizer_top.sv]
// top level of the utf-8 validating pretokenizer
// Text bytes enter through an input register, one transaction per cycle while the
// result side keeps up; each byte is decoded in one pass into 0 to 5 results (word
// bytes and an end marker), which a result register hands out one per cycle while
// out_ready is high, and then bytes yielding at most one result pass one per cycle.
// A byte yielding more holds the result register until all its results are taken.
// The case-fold register resets to 1 and is written through cfg_we/cfg_wdata; the
// user must write it only while no text is in flight, the block does not enforce it.
module utf8_validating_pretokenizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       word_start,
	output logic [1:0] kind,
	output logic       last_of_run
);
	import utf8vp_pkg::*;

	logic       lowercase_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eot_s1;
	seq_state_t st_q;
	seq_state_t st_nxt;
	held_t      held_q;
	held_t      held_nxt;
	bundle_t    bun;
	logic       free;
	logic       advance;

	assign advance  = valid_s1 && free;
	assign in_ready = !valid_s1 || free;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowercase_q <= 1'b1;
		end else if (cfg_we) begin
			lowercase_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eot_s1  <= end_of_text;
		end
	end

	// sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_q <= held_nxt;
		end
	end

	utf8vp_decode u_decode (
		.lowercase (lowercase_q),
		.data      (data_s1),
		.eot       (eot_s1),
		.st        (st_q),
		.held      (held_q),
		.nxt       (st_nxt),
		.nxt_held  (held_nxt),
		.bun       (bun)
	);

	utf8vp_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.bun         (bun),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.word_start  (word_start),
		.kind        (kind),
		.last_of_run (last_of_run)
	);

endmodule

[tb/utf8_token_checker.sv]
// result checker for the pretokenizer: watches both channels, predicts tokens and compares
module utf8_token_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       word_start,
	input  logic [1:0] kind,
	input  logic       last_of_run,
	output int         mismatch_count,
	output int         tokens_due
);
	import utf8vp_pkg::*;

	// one expected output transaction
	typedef struct {
		logic [7:0] value;
		logic       start;
		logic [1:0] kind;
		logic       is_last;
	} token_t;

	token_t token_q[$];
	token_t want;
	int     fail_tally = 0;

	// predicted copy of the block state
	logic        fold_upper;
	logic        in_word;
	logic [7:0]  held [3];
	logic [2:0]  seq_len;
	logic [1:0]  held_n;
	logic [20:0] scalar_acc;
	logic        text_bad;

	function automatic logic is_blank(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
	endfunction

	function automatic logic is_mark(input logic [7:0] b);
		return (b >= 8'h21 && b <= 8'h2f) || (b >= 8'h3a && b <= 8'h40) ||
			(b >= 8'h5b && b <= 8'h60) || (b >= 8'h7b && b <= 8'h7e);
	endfunction

	function automatic token_t make_token(input logic [7:0] v, input logic s,
		input logic [1:0] k);
		token_t t;
		t.value   = v;
		t.start   = s;
		t.kind    = k;
		t.is_last = 1'b0;
		return t;
	endfunction

	task automatic report_mismatch(input string what);
		fail_tally++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// error: the rest of the text is swallowed
	task automatic abandon_text();
		text_bad   = 1'b1;
		seq_len    = 3'd0;
		held_n     = 2'd0;
		scalar_acc = '0;
		in_word    = 1'b0;
	endtask

	task automatic clear_text();
		in_word    = 1'b0;
		seq_len    = 3'd0;
		held_n     = 2'd0;
		scalar_acc = '0;
		text_bad   = 1'b0;
	endtask

	// open a multi-byte sequence on a lead byte
	task automatic open_sequence(input logic [7:0] b, input logic [2:0] len,
		input logic [20:0] bits);
		in_word    = 1'b0;
		held[0]    = b;
		held_n     = 2'd1;
		seq_len    = len;
		scalar_acc = bits;
	endtask

	// decode one input byte into the tokens it releases
	task automatic predict_tokens(input logic [7:0] b, input logic eot);
		token_t     run[$];
		logic [7:0] c;
		logic       scalar_bad;
		int         i;
		if (!text_bad) begin
			if (seq_len != 3'd0) begin
				if (b[7:6] != 2'b10) begin
					abandon_text();
				end else begin
					scalar_acc = {scalar_acc[14:0], b[5:0]};
					if ({1'b0, held_n} + 3'd1 >= seq_len) begin
						scalar_bad = (seq_len == 3'd3 && scalar_acc < MIN_3BYTE) ||
							(seq_len == 3'd4 && scalar_acc < MIN_4BYTE) ||
							(scalar_acc >= SURR_LO && scalar_acc <= SURR_HI) ||
							scalar_acc > SCALAR_MAX;
						if (scalar_bad) begin
							abandon_text();
						end else begin
							for (i = 0; i < held_n; i++)
								run = {run, make_token(held[i], i == 0, KIND_WORD)};
							run = {run, make_token(b, 1'b0, KIND_WORD)};
							seq_len    = 3'd0;
							held_n     = 2'd0;
							scalar_acc = '0;
							in_word    = 1'b0;
						end
					end else if (held_n != 2'd3) begin
						held[held_n] = b;
						held_n++;
					end else begin
						abandon_text();
					end
				end
			end else if (b[7] == 1'b0) begin
				if (is_blank(b)) begin
					in_word = 1'b0;
				end else if (is_mark(b)) begin
					run = {run, make_token(b, 1'b1, KIND_WORD)};
					in_word = 1'b0;
				end else begin
					c = (fold_upper && b >= UPPER_A && b <= UPPER_Z) ? b + CASE_DELTA : b;
					run = {run, make_token(c, !in_word, KIND_WORD)};
					in_word = 1'b1;
				end
			end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
				open_sequence(b, 3'd2, {16'd0, b[4:0]});
			end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
				open_sequence(b, 3'd3, {17'd0, b[3:0]});
			end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
				open_sequence(b, 3'd4, {18'd0, b[2:0]});
			end else begin
				abandon_text();
			end
		end
		// end marker, then a fresh text
		if (eot) begin
			run = {run, make_token(8'h00, 1'b0,
				(text_bad || seq_len != 3'd0) ? KIND_END_BAD : KIND_END_OK)};
			clear_text();
		end
		foreach (run[k]) begin
			run[k].is_last = (k == run.size() - 1);
			token_q = {token_q, run[k]};
		end
	endtask

	// track config, predict on input transactions, compare output transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_upper = 1'b1;
			held[0]    = 8'h00;
			held[1]    = 8'h00;
			held[2]    = 8'h00;
			clear_text();
			token_q.delete();
			tokens_due     <= 0;
			mismatch_count <= fail_tally;
		end else begin
			if (cfg_we)
				fold_upper = cfg_wdata;
			if (in_valid && in_ready === 1'b1)
				predict_tokens(data_byte, end_of_text);
			if (out_valid === 1'b1 && out_ready) begin
				if (token_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %h kind %0d",
						out_byte, kind));
				end else begin
					want = token_q.pop_front();
					if (out_byte !== want.value)
						report_mismatch($sformatf("out_byte %h, expected %h",
							out_byte, want.value));
					if (word_start !== want.start)
						report_mismatch($sformatf("word_start %b, expected %b",
							word_start, want.start));
					if (kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
					if (last_of_run !== want.is_last)
						report_mismatch($sformatf("last_of_run %b, expected %b",
							last_of_run, want.is_last));
				end
			end
			tokens_due     <= token_q.size();
			mismatch_count <= fail_tally;
		end
	end

endmodule

[tb/testbench.sv]
// testbench top: feeds byte texts and case folding settings to the pretokenizer, gives the verdict
module testbench;

	localparam int LONG_HOLD   = 200;
	localparam int PHASE_ITEMS = 65;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_we      = 1'b0;
	logic       cfg_wdata   = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte   = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] out_byte;
	logic       word_start;
	logic [1:0] kind;
	logic       last_of_run;

	int mismatch_count;
	int tokens_due;
	bit gaps_on       = 1'b1;
	int hold_requests = 0;
	int hold_served   = 0;

	logic [7:0] text_q[$];

	// directed texts: bit 8 marks the last byte of a text
	logic [8:0] directed_q[$] = '{
		// letters folded, punctuation, delete and nul, 2-byte, 4-byte closing the text
		9'h041, 9'h05a, 9'h021, 9'h07f, 9'h000, 9'h0c2, 9'h080,
		9'h0f0, 9'h090, 9'h080, 9'h180,
		// overlong 3-byte form
		9'h0e0, 9'h080, 9'h180,
		// surrogate
		9'h0ed, 9'h0a0, 9'h180,
		// above the scalar range
		9'h0f4, 9'h090, 9'h080, 9'h180,
		// overlong 4-byte form
		9'h0f0, 9'h08f, 9'h0bf, 9'h1bf,
		// sequence cut off by the end of text
		9'h0e2, 9'h182,
		// lead followed by ascii
		9'h0c3, 9'h141,
		// byte that can never lead
		9'h1ff
	};

	utf8_validating_pretokenizer_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.word_start  (word_start),
		.kind        (kind),
		.last_of_run (last_of_run)
	);

	utf8_token_checker token_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_text    (end_of_text),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.word_start     (word_start),
		.kind           (kind),
		.last_of_run    (last_of_run),
		.mismatch_count (mismatch_count),
		.tokens_due     (tokens_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

	// result side: random stall bursts, plus long hold-offs on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
				hold_served++;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] cont_byte();
		return 8'h80 + 8'($urandom_range(0, 63));
	endfunction

	// append one byte to the text under construction
	task automatic add_byte(input logic [7:0] b);
		text_q = {text_q, b};
	endtask

	// offer one byte, maybe after an idle burst, and wait for its transaction
	task automatic send_byte(input logic [7:0] value, input logic eot);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= value;
		end_of_text <= eot;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i], i == text_q.size() - 1);
	endtask

	// stop offering and wait until every predicted result has come out
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tokens_due != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_fold(input logic value);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// build one random text from segments; untidy texts may carry broken sequences
	task automatic build_text();
		bit          tidy;
		int          segs;
		int          pick;
		int          n;
		bit          cut;
		bit          at_bound;
		bit          hi_side;
		logic [20:0] cp;
		logic [7:0]  b;
		text_q.delete();
		tidy = ($urandom_range(0, 4) != 0);
		segs = $urandom_range(1, 6);
		cut  = 1'b0;
		for (int s = 0; s < segs && !cut; s++) begin
			pick = tidy ? $urandom_range(0, 16) : $urandom_range(0, 24);
			case (pick)
				0, 1, 2, 3, 4, 5: begin
					// ascii word with mixed case and digits
					n = $urandom_range(1, 6);
					repeat (n) begin
						case ($urandom_range(0, 2))
							0: b = 8'h41 + 8'($urandom_range(0, 25));
							1: b = 8'h61 + 8'($urandom_range(0, 25));
							default: b = 8'h30 + 8'($urandom_range(0, 9));
						endcase
						add_byte(b);
					end
				end
				6, 7: begin
					b = 8'($urandom_range(0, 5));
					add_byte(b == 8'd5 ? 8'h20 : 8'h09 + b);
				end
				8, 9: begin
					case ($urandom_range(0, 3))
						0: b = 8'($urandom_range(8'h21, 8'h2f));
						1: b = 8'($urandom_range(8'h3a, 8'h40));
						2: b = 8'($urandom_range(8'h5b, 8'h60));
						default: b = 8'($urandom_range(8'h7b, 8'h7e));
					endcase
					add_byte(b);
				end
				10: add_byte(8'($urandom_range(0, 127)));
				11, 12, 13, 14, 15, 16: begin
					// well-formed scalar, sometimes at a range boundary
					n        = $urandom_range(2, 4);
					at_bound = ($urandom_range(0, 3) == 0);
					hi_side  = $urandom_range(0, 1);
					case (n)
						2: cp = at_bound ? (hi_side ? 21'h7ff : 21'h80) :
							21'($urandom_range(21'h80, 21'h7ff));
						3: cp = at_bound ? (hi_side ? 21'hffff : 21'h800) :
							21'($urandom_range(21'h800, 21'hffff));
						default: cp = at_bound ? (hi_side ? 21'h10ffff : 21'h10000) :
							21'($urandom_range(21'h10000, 21'h10ffff));
					endcase
					if (cp >= 21'hd800 && cp <= 21'hdfff)
						cp = cp - 21'h800;
					case (n)
						2: begin
							add_byte({3'b110, cp[10:6]});
							add_byte({2'b10, cp[5:0]});
						end
						3: begin
							add_byte({4'b1110, cp[15:12]});
							add_byte({2'b10, cp[11:6]});
							add_byte({2'b10, cp[5:0]});
						end
						default: begin
							add_byte({5'b11110, cp[20:18]});
							add_byte({2'b10, cp[17:12]});
							add_byte({2'b10, cp[11:6]});
							add_byte({2'b10, cp[5:0]});
						end
					endcase
				end
				17: add_byte(8'($urandom_range(0, 255)));
				18: add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hc1)) :
					8'($urandom_range(8'hf5, 8'hff)));
				19: begin
					// lead then a byte that is not a continuation
					add_byte(8'($urandom_range(8'hc2, 8'hf4)));
					b = 8'($urandom_range(0, 191));
					add_byte(b >= 8'h80 ? b + 8'h40 : b);
				end
				20: begin
					add_byte(8'he0);
					add_byte(8'($urandom_range(8'h80, 8'h9f)));
					add_byte(cont_byte());
				end
				21: begin
					add_byte(8'hed);
					add_byte(8'($urandom_range(8'ha0, 8'hbf)));
					add_byte(cont_byte());
				end
				22: begin
					add_byte(8'hf4);
					add_byte(8'($urandom_range(8'h90, 8'hbf)));
					add_byte(cont_byte());
					add_byte(cont_byte());
				end
				23: begin
					add_byte(8'hf0);
					add_byte(8'($urandom_range(8'h80, 8'h8f)));
					add_byte(cont_byte());
					add_byte(cont_byte());
				end
				default: begin
					// unfinished sequence closing the text
					n = $urandom_range(2, 4);
					case (n)
						2: add_byte(8'($urandom_range(8'hc2, 8'hdf)));
						3: add_byte(8'($urandom_range(8'he1, 8'hec)));
						default: add_byte(8'($urandom_range(8'hf1, 8'hf3)));
					endcase
					repeat ($urandom_range(0, n - 2)) add_byte(cont_byte());
					cut = 1'b1;
				end
			endcase
		end
		// a text is never empty
		if (text_q.size() == 0)
			add_byte(8'h20);
	endtask

	// reset, directed texts, random phases with folding changes, drain, verdict
	initial begin
		int  sent;
		bit  paused;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i])
			send_byte(directed_q[i][7:0], directed_q[i][8]);

		paused = 1'b0;
		for (int phase = 0; phase < 4; phase++) begin
			write_fold(phase[0]);
			// last phase runs without idling
			gaps_on = (phase != 3);
			// long result hold-off while bytes keep coming
			if (phase == 1)
				hold_requests <= hold_requests + 1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				build_text();
				send_text();
				sent += text_q.size();
				if (phase == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
					settle_idle();
					paused = 1'b1;
				end
			end
		end

		settle_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && tokens_due == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/utf8vp_pkg.sv
hdl/utf8vp_decode.sv
hdl/utf8vp_emit.sv
hdl/utf8_validating_pretokenizer_top.sv
tb/utf8_token_checker.sv
tb/testbench.sv
